// ===== rtl/mnpm_pkg.sv =====
// mnpm_pkg: shared types and constants of the MIDI note pair matcher.
// Word layouts of both channels, event kind codes, and the command and
// status bundles between controller and datapath. No dependencies.
package mnpm_pkg;

  localparam int PENDING_DEPTH_DEF = 32;
  localparam int ID_BITS_DEF       = 16;

  localparam int DELTA_W = 28;
  localparam int VEL_W   = 7;
  localparam int PITCH_W = 7;
  localparam int CHAN_W  = 4;
  localparam int EVID_W  = 16;
  localparam int TIME_W  = 32;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_ON    = 2'd1;
  localparam logic [1:0] KIND_OFF   = 2'd2;

  typedef struct packed {
    logic               restart;
    logic [1:0]         kind;
    logic [DELTA_W-1:0] delta_ticks;
    logic [VEL_W-1:0]   velocity;
    logic [PITCH_W-1:0] pitch;
    logic [CHAN_W-1:0]  channel;
    logic [EVID_W-1:0]  event_id;
  } in_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] absolute_time;
    logic              pair_found;
    logic [EVID_W-1:0] on_id;
    logic [EVID_W-1:0] off_id;
    logic              stored_pending;
    logic              dropped_full;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the accepted word, advance time
    logic store;   // append note-on to pending table
    logic scan;    // step the match / compaction sweep
    logic finish;  // load the result register, retire matched entry
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ev_on;
    logic ev_off;
    logic scan_busy;
  } ctl_stat_t;

endpackage

// ===== rtl/mnpm_ifs.sv =====
// mnpm_ifs: valid/ready channel interfaces for input and result words.
// Depends on mnpm_pkg for the word types.
interface mnpm_in_if;
  logic                valid;
  logic                ready;
  mnpm_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mnpm_out_if;
  logic                valid;
  logic                ready;
  mnpm_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/midi_note_pair_matcher_unit.sv =====
// midi_note_pair_matcher_unit: top level of the MIDI note on/off pairing block.
// Instantiates mnpm_ctrl and mnpm_dpath; depends on mnpm_pkg and mnpm_ifs.
//
// Usage: drive one MIDI event word on in_chan (valid/ready). Each accepted
// word yields exactly one result word on out_chan, in order: the wrapping
// 32-bit absolute time, and either a matched on/off id pair, a stored flag
// or a dropped-full flag. Note-ons go into an ordered pending table; an off
// closes the oldest pending entry with the same pitch and channel.
// Sequence: a word is loaded in the idle state, then passes the execute and
// finish states. An off also sweeps the table in a scan state between
// them, one entry per cycle through the single read port of the pending
// memory, compacting in the same pass, over all pending entries (at most
// PENDING_DEPTH).
// One word is in work at a time; the next is accepted once the current
// result sits in the output register, even if that word is not yet taken.
// Stall: a result not taken holds the output register, and a finished word
// waits for it before the block accepts another.
// Reset: rst_n low clears running time, pending count and output valid; the
// block comes out of reset idle and ready. The restart bit of a word
// clears time and table before that word is applied.
module midi_note_pair_matcher_unit #(
  parameter int PENDING_DEPTH = mnpm_pkg::PENDING_DEPTH_DEF,
  parameter int ID_BITS       = mnpm_pkg::ID_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mnpm_in_if.sink    in_chan,
  mnpm_out_if.source out_chan
);

  mnpm_pkg::ctl_cmd_t  cmd;
  mnpm_pkg::ctl_stat_t stat;

  // sequencer: handshakes on both channels, commands to the datapath
  mnpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: time accumulator, pending table and result word register
  mnpm_dpath #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .ID_BITS       (ID_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_chan.data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_chan.data)
  );

endmodule

// ===== rtl/mnpm_dpath.sv =====
// mnpm_dpath: running time, pending table memory, match/compaction sweep
// and result register. Driven by mnpm_ctrl; depends on mnpm_pkg.
module mnpm_dpath #(
  parameter int PENDING_DEPTH = mnpm_pkg::PENDING_DEPTH_DEF,
  parameter int ID_BITS       = mnpm_pkg::ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mnpm_pkg::in_word_t  in_data,
  input  mnpm_pkg::ctl_cmd_t  cmd,
  output mnpm_pkg::ctl_stat_t stat,
  output mnpm_pkg::out_word_t out_data
);

  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);

  typedef struct packed {
    logic [mnpm_pkg::PITCH_W-1:0] pitch;
    logic [mnpm_pkg::CHAN_W-1:0]  chan;
    logic [ID_BITS-1:0]           id;
  } entry_t;

  entry_t mem [PENDING_DEPTH];

  logic [mnpm_pkg::TIME_W-1:0]  time_r;
  logic [CW-1:0]                count_r;
  logic [mnpm_pkg::PITCH_W-1:0] ev_pitch_r;
  logic [mnpm_pkg::CHAN_W-1:0]  ev_chan_r;
  logic [ID_BITS-1:0]           ev_id_r;
  logic                         ev_on_r;
  logic                         ev_off_r;
  logic [CW-1:0]                rd_idx_r;
  logic                         rdv_r;
  entry_t                       rd_data_r;
  logic [AW-1:0]                data_idx_r;
  logic                         matched_r;
  logic [ID_BITS-1:0]           on_id_r;
  logic                         stored_r;
  logic                         dropped_r;
  mnpm_pkg::out_word_t          out_data_r;

  logic    full;
  logic    rd_issue;
  logic    hit;
  logic    mem_we;
  logic [AW-1:0] mem_wa;
  entry_t  mem_wd;
  logic    is_off_in;
  logic    is_on_in;

  assign full     = (count_r == CW'(PENDING_DEPTH));
  assign rd_issue = cmd.scan && (rd_idx_r < count_r);
  assign hit      = (rd_data_r.pitch == ev_pitch_r) && (rd_data_r.chan == ev_chan_r);

  assign is_off_in = (in_data.kind == mnpm_pkg::KIND_OFF) ||
                     ((in_data.kind == mnpm_pkg::KIND_ON) && (in_data.velocity == '0));
  assign is_on_in  = (in_data.kind == mnpm_pkg::KIND_ON) && (in_data.velocity != '0);

  // single write port: append on store, shift one place down while compacting
  always_comb begin
    mem_we = (cmd.store && !full) || (cmd.scan && rdv_r && matched_r);
    if (cmd.store) begin
      mem_wa = count_r[AW-1:0];
      mem_wd = '{pitch: ev_pitch_r, chan: ev_chan_r, id: ev_id_r};
    end else begin
      mem_wa = data_idx_r - AW'(1);
      mem_wd = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_issue) begin
      rd_data_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  // time and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.load) begin
        time_r  <= (in_data.restart ? '0 : time_r) +
                   mnpm_pkg::TIME_W'(in_data.delta_ticks);
        count_r <= in_data.restart ? '0 : count_r;
      end else if (cmd.store && !full) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.finish && matched_r) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // event capture and sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r     <= 1'b0;
      matched_r <= 1'b0;
      rd_idx_r  <= '0;
    end else if (cmd.load) begin
      rdv_r     <= 1'b0;
      matched_r <= 1'b0;
      rd_idx_r  <= '0;
    end else if (cmd.scan) begin
      rdv_r      <= rd_issue;
      data_idx_r <= rd_idx_r[AW-1:0];
      if (rd_issue) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      // first hit is the oldest; later entries only move up
      if (rdv_r && !matched_r && hit) begin
        matched_r <= 1'b1;
        on_id_r   <= rd_data_r.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ev_pitch_r <= in_data.pitch;
      ev_chan_r  <= in_data.channel;
      ev_id_r    <= ID_BITS'(in_data.event_id);
      ev_on_r    <= is_on_in;
      ev_off_r   <= is_off_in;
      stored_r   <= 1'b0;
      dropped_r  <= 1'b0;
    end else if (cmd.store) begin
      stored_r  <= !full;
      dropped_r <= full;
    end
    if (cmd.finish) begin
      out_data_r.absolute_time  <= time_r;
      out_data_r.pair_found     <= matched_r;
      out_data_r.on_id          <= matched_r ? mnpm_pkg::EVID_W'(on_id_r) : '0;
      out_data_r.off_id         <= matched_r ? mnpm_pkg::EVID_W'(ev_id_r) : '0;
      out_data_r.stored_pending <= stored_r;
      out_data_r.dropped_full   <= dropped_r;
    end
  end

  assign stat.ev_on     = ev_on_r;
  assign stat.ev_off    = ev_off_r;
  assign stat.scan_busy = (rd_idx_r < count_r) || rdv_r;
  assign out_data       = out_data_r;

endmodule

// ===== rtl/mnpm_ctrl.sv =====
// mnpm_ctrl: sequencing state machine and result-valid flag.
// Issues commands to mnpm_dpath; depends on mnpm_pkg.
module mnpm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mnpm_pkg::ctl_stat_t stat,
  output mnpm_pkg::ctl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.ev_off) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.store = stat.ev_on;
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (!stat.scan_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== tb/sv/mnpm_pair_checker.sv =====
`timescale 1ns / 1ps
// mnpm_pair_checker: watches both channels of the note pair matcher, keeps
// its own running time and table of held notes, and checks every result word.
// Depends on mnpm_pkg and the channel interfaces in mnpm_ifs.
module mnpm_pair_checker #(
  parameter int PENDING_DEPTH = mnpm_pkg::PENDING_DEPTH_DEF,
  parameter int ID_BITS       = mnpm_pkg::ID_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mnpm_in_if   in_mon,
  mnpm_out_if  out_mon,
  input  logic final_check,
  output int   fail_count,
  output int   results_owed
);
  import mnpm_pkg::*;

  localparam logic [EVID_W-1:0] ID_MASK =
    (ID_BITS >= EVID_W) ? {EVID_W{1'b1}} : EVID_W'((1 << ID_BITS) - 1);

  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic [CHAN_W-1:0]  channel;
    logic [EVID_W-1:0]  id;
  } held_note_t;

  logic [TIME_W-1:0] tick_count = '0;
  held_note_t        held_notes[$];
  out_word_t         expected_words[$];
  int                mismatches = 0;
  int                owed = 0;
  bit                leftover_checked = 1'b0;

  assign fail_count   = mismatches;
  assign results_owed = owed;

  // Apply one event to the held-note table and return the word it should yield.
  function automatic out_word_t pair_event(in_word_t w);
    out_word_t         r;
    held_note_t        n;
    bit                hit;
    logic [EVID_W-1:0] id;
    r   = '0;
    hit = 1'b0;
    id  = w.event_id & ID_MASK;
    if (w.restart) begin
      tick_count = '0;
      held_notes.delete();
    end
    tick_count = tick_count + TIME_W'(w.delta_ticks);
    r.absolute_time = tick_count;
    if (w.kind == KIND_OFF || (w.kind == KIND_ON && w.velocity == '0)) begin
      // oldest matching note wins; later notes move up
      for (int i = 0; i < held_notes.size() && !hit; i++) begin
        if (held_notes[i].pitch == w.pitch && held_notes[i].channel == w.channel) begin
          hit          = 1'b1;
          r.pair_found = 1'b1;
          r.on_id      = held_notes[i].id;
          r.off_id     = id;
          held_notes.delete(i);
        end
      end
    end else if (w.kind == KIND_ON) begin
      if (held_notes.size() < PENDING_DEPTH) begin
        n.pitch   = w.pitch;
        n.channel = w.channel;
        n.id      = id;
        held_notes.push_back(n);
        r.stored_pending = 1'b1;
      end else begin
        r.dropped_full = 1'b1;
      end
    end
    return r;
  endfunction

  // Count every mismatch and print one line for it.
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    out_word_t got;
    out_word_t want;
    if (!rst_n) begin
      tick_count = '0;
      held_notes.delete();
      expected_words.delete();
      owed = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_words.size() == 0) begin
          report("unexpected result word, absolute_time", got.absolute_time, '0);
        end else begin
          want = expected_words.pop_front();
          if (got.absolute_time !== want.absolute_time)
            report("absolute_time", got.absolute_time, want.absolute_time);
          if (got.pair_found !== want.pair_found)
            report("pair_found", 32'(got.pair_found), 32'(want.pair_found));
          if (got.on_id !== want.on_id)
            report("on_id", 32'(got.on_id), 32'(want.on_id));
          if (got.off_id !== want.off_id)
            report("off_id", 32'(got.off_id), 32'(want.off_id));
          if (got.stored_pending !== want.stored_pending)
            report("stored_pending", 32'(got.stored_pending), 32'(want.stored_pending));
          if (got.dropped_full !== want.dropped_full)
            report("dropped_full", 32'(got.dropped_full), 32'(want.dropped_full));
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_words.push_back(pair_event(in_mon.data));
      owed = expected_words.size();
      if (final_check && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (owed != 0) report("result words never delivered", '0, 32'(owed));
      end
    end
  end

endmodule

// ===== tb/sv/midi_note_pair_matcher_unit_tb.sv =====
`timescale 1ns / 1ps
// midi_note_pair_matcher_unit_tb: stimulus and verdict for the note pair matcher.
// Depends on mnpm_pkg, mnpm_ifs, the block itself and mnpm_pair_checker.
module midi_note_pair_matcher_unit_tb;
  import mnpm_pkg::*;

  localparam int PENDING_DEPTH = PENDING_DEPTH_DEF;
  localparam int ID_BITS       = ID_BITS_DEF;

  // Kind code with no meaning; the block must treat it as an other event.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int ITEMS_PER_PHASE = 440;
  localparam int HOLD_CYCLES     = 400;
  // Drain margin past the longest off sweep, the one over a full table.
  localparam int DRAIN_CYCLES    = PENDING_DEPTH + 16;

  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic [CHAN_W-1:0]  chan;
  } note_key_t;

  logic clk = 1'b0;
  logic rst_n;
  logic final_check;
  int   fail_count;
  int   results_owed;

  // Idling knobs, in percent per cycle, changed per phase.
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  // Long receiver hold-offs asked by the stimulus and served by the receiver.
  int   hold_requests = 0;
  int   hold_served = 0;

  // Notes the stimulus believes are held, used to aim note-offs and to fill or empty the table.
  note_key_t held_keys[$];

  mnpm_in_if  in_chan();
  mnpm_out_if out_chan();

  midi_note_pair_matcher_unit #(
    .PENDING_DEPTH(PENDING_DEPTH),
    .ID_BITS      (ID_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  mnpm_pair_checker #(
    .PENDING_DEPTH(PENDING_DEPTH),
    .ID_BITS      (ID_BITS)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .final_check (final_check),
    .fail_count  (fail_count),
    .results_owed(results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Safety net: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("midi_note_pair_matcher_unit verification failed");
    $finish;
  end

  // Receiver: drive ready at every falling edge. A pending hold request wins
  // and keeps ready low for a counted stretch so the block backs up into
  // its input; otherwise stall at the rate of the current phase.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  function automatic in_word_t make_event(logic restart, logic [1:0] kind,
                                          logic [DELTA_W-1:0] delta,
                                          logic [VEL_W-1:0] vel,
                                          logic [PITCH_W-1:0] pitch,
                                          logic [CHAN_W-1:0] chan,
                                          logic [EVID_W-1:0] id);
    in_word_t w;
    w.restart     = restart;
    w.kind        = kind;
    w.delta_ticks = delta;
    w.velocity    = vel;
    w.pitch       = pitch;
    w.channel     = chan;
    w.event_id    = id;
    return w;
  endfunction

  // Mostly short deltas, with zero, the maximum and full-range values mixed in.
  function automatic logic [DELTA_W-1:0] pick_delta();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return {DELTA_W{1'b1}};
    if (r == 1) return DELTA_W'($urandom);
    if (r <= 3) return '0;
    return DELTA_W'($urandom_range(1, 2000));
  endfunction

  // Offer one word at a falling edge and hold it until it is taken. Enter and
  // leave at a falling edge so valid gets exactly one update per step.
  task automatic send_note(input in_word_t w);
    bit hit;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= w;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    @(negedge clk);
    // Track held notes the same way the block does, to aim later offs.
    hit = 1'b0;
    if (w.restart) held_keys.delete();
    if (w.kind == KIND_OFF || (w.kind == KIND_ON && w.velocity == '0)) begin
      for (int i = 0; i < held_keys.size() && !hit; i++) begin
        if (held_keys[i].pitch == w.pitch && held_keys[i].chan == w.channel) begin
          held_keys.delete(i);
          hit = 1'b1;
        end
      end
    end else if (w.kind == KIND_ON && held_keys.size() < PENDING_DEPTH) begin
      held_keys.push_back({w.pitch, w.channel});
    end
  endtask

  // Note-on with nonzero velocity; pooled keys collide often and pair up.
  task automatic send_random_on(bit pooled);
    logic [PITCH_W-1:0] pitch;
    logic [CHAN_W-1:0]  chan;
    if (pooled) begin
      pitch = PITCH_W'($urandom_range(60, 65));
      chan  = CHAN_W'($urandom_range(0, 1));
    end else begin
      pitch = PITCH_W'($urandom_range(0, 127));
      chan  = CHAN_W'($urandom_range(0, 15));
    end
    send_note(make_event(1'b0, KIND_ON, pick_delta(), VEL_W'($urandom_range(1, 127)),
                         pitch, chan, EVID_W'($urandom)));
  endtask

  // Note-off, either aimed at a held note (any age) or at a random key.
  // A quarter of them are note-ons with velocity zero.
  task automatic send_random_off(bit aimed);
    note_key_t          k;
    logic [1:0]         kind;
    logic [VEL_W-1:0]   vel;
    if (aimed && held_keys.size() != 0) begin
      k = held_keys[$urandom_range(0, held_keys.size() - 1)];
    end else begin
      k.pitch = PITCH_W'($urandom_range(0, 127));
      k.chan  = CHAN_W'($urandom_range(0, 15));
    end
    if ($urandom_range(0, 3) == 0) begin
      kind = KIND_ON;
      vel  = '0;
    end else begin
      kind = KIND_OFF;
      vel  = VEL_W'($urandom_range(0, 127));
    end
    send_note(make_event(1'b0, kind, pick_delta(), vel, k.pitch, k.chan,
                         EVID_W'($urandom)));
  endtask

  // Any event of the given kind with every other field random.
  task automatic send_loose(logic restart, logic [1:0] kind, logic [DELTA_W-1:0] delta);
    send_note(make_event(restart, kind, delta, VEL_W'($urandom), PITCH_W'($urandom),
                         CHAN_W'($urandom), EVID_W'($urandom)));
  endtask

  // One random stretch of traffic; returns the number of words sent.
  task automatic send_segment(output int count);
    int r;
    int k;
    count = 0;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      // mostly ons and offs on a small key pool, with other-kind and restart words
      repeat (16) begin
        k = $urandom_range(0, 199);
        if (k == 0)       send_loose(1'b1, KIND_OTHER, pick_delta());
        else if (k < 100) send_random_on($urandom_range(0, 4) != 0);
        else if (k < 170) send_random_off($urandom_range(0, 6) != 0);
        else if (k < 190) send_loose(1'b0, KIND_OTHER, pick_delta());
        else              send_loose(1'b0, KIND_UNUSED, pick_delta());
        count++;
      end
    end else if (r < 67) begin
      // fill the table, then push a few more that must be dropped
      if ($urandom_range(0, 3) == 0) begin
        send_loose(1'b1, KIND_OTHER, pick_delta());
        count++;
      end
      while (held_keys.size() < PENDING_DEPTH) begin
        send_random_on($urandom_range(0, 1));
        count++;
      end
      repeat ($urandom_range(1, 3)) begin
        send_random_on(1'b1);
        count++;
      end
    end else if (r < 80) begin
      // close every held note in random order, then one stray off
      while (held_keys.size() != 0) begin
        send_random_off(1'b1);
        count++;
      end
      send_random_off(1'b0);
      count++;
    end else if (r < 92) begin
      // noise: every field random, restart now and then
      repeat (8) begin
        send_loose($urandom_range(0, 7) == 0, 2'($urandom_range(0, 3)), DELTA_W'($urandom));
        count++;
      end
    end else begin
      // maximum deltas, enough to wrap the 32-bit time at least once
      repeat (18) begin
        send_note(make_event(1'b0, 2'($urandom_range(0, 2)), {DELTA_W{1'b1}},
                             VEL_W'($urandom), PITCH_W'($urandom_range(60, 65)),
                             CHAN_W'($urandom_range(0, 1)), EVID_W'($urandom)));
        count++;
      end
    end
  endtask

  initial begin : stimulus
    int sent;
    int got;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    final_check   = 1'b0;
    rst_n         = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, kind three, duplicates, matches at the head
    // and in the middle, unmatched offs, velocity-zero offs and restarts.
    send_note(make_event(1'b0, KIND_OTHER, '0, '0, '0, '0, '0));
    send_note(make_event(1'b0, KIND_OTHER, {DELTA_W{1'b1}}, 7'd127, 7'd127, 4'd15, 16'hFFFF));
    send_note(make_event(1'b0, KIND_UNUSED, 28'd7, 7'd127, 7'd60, 4'd3, 16'h1234));
    send_note(make_event(1'b0, KIND_ON, 28'd1, 7'd1, 7'd0, 4'd0, 16'h0001));
    send_note(make_event(1'b0, KIND_ON, 28'd2, 7'd127, 7'd127, 4'd15, 16'hFFFF));
    send_note(make_event(1'b0, KIND_ON, 28'd3, 7'd64, 7'd60, 4'd3, 16'h000A));
    send_note(make_event(1'b0, KIND_ON, 28'd4, 7'd100, 7'd60, 4'd3, 16'h000B));
    send_note(make_event(1'b0, KIND_OFF, 28'd5, 7'd0, 7'd60, 4'd3, 16'h0014));
    send_note(make_event(1'b0, KIND_ON, 28'd6, 7'd0, 7'd60, 4'd3, 16'h0015));
    send_note(make_event(1'b0, KIND_OFF, 28'd0, 7'd40, 7'd61, 4'd3, 16'h0016));
    send_note(make_event(1'b0, KIND_OFF, 28'd0, 7'd40, 7'd60, 4'd4, 16'h0017));
    send_note(make_event(1'b0, KIND_OFF, 28'd9, 7'd127, 7'd0, 4'd0, 16'h0018));
    send_note(make_event(1'b1, KIND_ON, 28'd5, 7'd9, 7'd127, 4'd15, 16'h001E));
    send_note(make_event(1'b0, KIND_OFF, 28'd1, 7'd0, 7'd127, 4'd15, 16'h001F));
    send_note(make_event(1'b0, KIND_OFF, 28'd1, 7'd0, 7'd127, 4'd15, 16'h0020));
    send_note(make_event(1'b1, KIND_OTHER, '0, '0, '0, '0, '0));
    send_note(make_event(1'b0, KIND_OFF, {DELTA_W{1'b1}}, 7'd127, 7'd0, 4'd0, 16'hFFFF));

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          // long receiver hold-off while the sender keeps offering
          hold_requests++;
        end
        1: begin
          tx_idle_pct  = 68;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 68;
        end
        default: begin
          tx_idle_pct  = 21;
          rx_stall_pct = 21;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        send_segment(got);
        sent += got;
      end
    end

    in_chan.valid <= 1'b0;
    rx_stall_pct = 0;
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    final_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("midi_note_pair_matcher_unit verification clean");
    end else begin
      $display("midi_note_pair_matcher_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mnpm_pkg.sv
rtl/mnpm_ifs.sv
rtl/mnpm_dpath.sv
rtl/mnpm_ctrl.sv
rtl/midi_note_pair_matcher_unit.sv
tb/sv/mnpm_pair_checker.sv
tb/sv/midi_note_pair_matcher_unit_tb.sv
